// ----- hdl/lexicographic_permutation_stepper_core_defines.svh -----
// ----------------------------------------------------------------------------
// lexicographic_permutation_stepper_core_defines
// assertion macros shared by the permutation stepper rtl
// ----------------------------------------------------------------------------
`ifndef LEXICOGRAPHIC_PERMUTATION_STEPPER_CORE_DEFINES_SVH
`define LEXICOGRAPHIC_PERMUTATION_STEPPER_CORE_DEFINES_SVH

// same-cycle implication
`define LPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lps assertion failed");

// next-cycle implication
`define LPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lps assertion failed");

`endif

// ----- hdl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// shared types and constants of the permutation stepper
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    localparam int MAX_ELEMENTS_DEF = 8;
    localparam int VALUE_BITS_DEF   = 16;

    // fixed port field widths
    localparam int INDEX_BITS    = 3;
    localparam int ELEM_BITS     = 16;
    localparam int POS_BITS      = 3;
    localparam int LEN_BITS      = 4;
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 24;

    localparam logic [LEN_BITS-1:0] LEN_RESET  = 4'd4;
    localparam int                  MIN_LENGTH = 2;

    // apb register map
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
    localparam logic [REG_IDX_BITS-1:0] REG_LENGTH = 1'b0;

    // input kinds carried on tuser
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // command queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                  is_advance;
        logic [INDEX_BITS-1:0] index;
        logic [ELEM_BITS-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic final_arr;
    } snap_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SORT,
        ENG_SWAP
    } eng_state_t;

endpackage

`default_nettype wire

// ----- hdl/lps_front.sv -----
// ----------------------------------------------------------------------------
// lps_front
// accepts input transactions, drops out-of-range loads, queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module lps_front import lps_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [IN_DATA_BITS-1:0] s_tdata,
    input  wire logic                    s_tuser,
    output logic                         cmd_valid,
    output cmd_t                         cmd,
    input  wire logic                    cmd_ready
);

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t            q_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;

    cmd_t in_cmd;
    logic keep;
    logic push;
    logic pop;

    always_comb
    begin
        in_cmd.is_advance = (s_tuser == MODE_ADVANCE);
        in_cmd.index      = s_tdata[INDEX_BITS-1:0];
        in_cmd.value      = s_tdata[INDEX_BITS +: ELEM_BITS];
        // loads beyond the store are dropped here
        keep = in_cmd.is_advance || (32'(in_cmd.index) < 32'(MAX_ELEMENTS));
    end

    assign s_tready  = (count_reg != QC_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QP_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QP_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QC_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lps_engine.sv -----
// ----------------------------------------------------------------------------
// lps_engine
// element store, snapshot for emission and next-permutation stepping
// ----------------------------------------------------------------------------
`default_nettype none

module lps_engine import lps_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cmd_valid,
    input  wire cmd_t                                    cmd,
    output logic                                         cmd_ready,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]       active_len,
    input  wire logic                                    emit_idle,
    output snap_t                                        snap,
    output logic [MAX_ELEMENTS-1:0][ELEM_BITS-1:0]       snap_elems
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    eng_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] store_reg  [MAX_ELEMENTS];
    logic [VALUE_BITS-1:0] store_next [MAX_ELEMENTS];

    logic [CNT_W-1:0]      pass_reg, pass_next;
    logic                  phase_reg, phase_next;
    logic                  has_pivot_reg, has_pivot_next;
    logic [IDX_W-1:0]      pivot_reg, pivot_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [VALUE_BITS-1:0] pv_reg, pv_next;

    logic                    piv_found;
    logic [IDX_W-1:0]        piv_idx;
    logic [IDX_W-1:0]        swap_idx;
    logic [IDX_W-1:0]        rd_idx;
    logic [VALUE_BITS-1:0]   rd_data;
    logic [MAX_ELEMENTS-2:0] sort_swap;
    logic                    do_load;
    logic                    do_start;

    // rightmost rising neighbor pair inside the active length
    always_comb
    begin
        piv_found = 1'b0;
        piv_idx   = '0;
        for (int i = 0; i < MAX_ELEMENTS - 1; i++)
        begin
            if ((store_reg[i] < store_reg[i+1]) && (CNT_W'(i + 1) < active_len))
            begin
                piv_found = 1'b1;
                piv_idx   = IDX_W'(i);
            end
        end
    end

    // suffix is sorted by now: leftmost entry above the pivot value
    always_comb
    begin
        swap_idx = '0;
        for (int i = MAX_ELEMENTS - 1; i > 0; i--)
        begin
            if ((store_reg[i] > pv_reg) && (IDX_W'(i) > pivot_reg)
                && (CNT_W'(i) < active_len))
            begin
                swap_idx = IDX_W'(i);
            end
        end
    end

    // single shared read port
    assign rd_idx  = (state_reg == ENG_IDLE) ? piv_idx : swap_idx;
    assign rd_data = store_reg[rd_idx];

    // odd-even transposition pass over the suffix
    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS - 1; i++)
        begin
            sort_swap[i] = (state_reg == ENG_SORT) && (1'(i) == phase_reg)
                           && (IDX_W'(i) >= lo_reg) && (CNT_W'(i + 1) < active_len)
                           && (store_reg[i] > store_reg[i+1]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            snap_elems[i] = ELEM_BITS'(store_reg[i]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (cmd_valid && cmd.is_advance && emit_idle)
                begin
                    state_next = ENG_SORT;
                end
            end
            ENG_SORT:
            begin
                if (pass_reg == CNT_W'(1))
                begin
                    state_next = has_pivot_reg ? ENG_SWAP : ENG_IDLE;
                end
            end
            ENG_SWAP:
            begin
                state_next = ENG_IDLE;
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_ready      = 1'b0;
        do_load        = 1'b0;
        do_start       = 1'b0;
        snap.valid     = 1'b0;
        snap.final_arr = !piv_found;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (cmd_valid && !cmd.is_advance)
                begin
                    cmd_ready = 1'b1;
                    do_load   = 1'b1;
                end
                else if (cmd_valid && emit_idle)
                begin
                    cmd_ready  = 1'b1;
                    do_start   = 1'b1;
                    snap.valid = 1'b1;
                end
            end
            ENG_SORT,
            ENG_SWAP:
            begin
                cmd_ready = 1'b0;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        pass_next      = pass_reg;
        phase_next     = phase_reg;
        has_pivot_next = has_pivot_reg;
        pivot_next     = pivot_reg;
        lo_next        = lo_reg;
        pv_next        = pv_reg;
        if (do_start)
        begin
            pass_next      = active_len;
            phase_next     = 1'b0;
            has_pivot_next = piv_found;
            pivot_next     = piv_idx;
            lo_next        = piv_found ? piv_idx + IDX_W'(1) : '0;
            pv_next        = rd_data;
        end
        else if (state_reg == ENG_SORT)
        begin
            pass_next  = pass_reg - CNT_W'(1);
            phase_next = !phase_reg;
        end
    end

    always_comb
    begin
        store_next = store_reg;
        if (do_load)
        begin
            for (int i = 0; i < MAX_ELEMENTS; i++)
            begin
                if (32'(cmd.index) == 32'(i))
                begin
                    store_next[i] = VALUE_BITS'(cmd.value);
                end
            end
        end
        for (int i = 0; i < MAX_ELEMENTS - 1; i++)
        begin
            if (sort_swap[i])
            begin
                store_next[i]   = store_reg[i+1];
                store_next[i+1] = store_reg[i];
            end
        end
        if (state_reg == ENG_SWAP)
        begin
            store_next[pivot_reg] = rd_data;
            store_next[swap_idx]  = pv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            pass_reg      <= '0;
            phase_reg     <= 1'b0;
            has_pivot_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            phase_reg     <= phase_next;
            has_pivot_reg <= has_pivot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pivot_reg <= pivot_next;
        lo_reg    <= lo_next;
        pv_reg    <= pv_next;
        store_reg <= store_next;
    end

endmodule

`default_nettype wire

// ----- hdl/lps_emit.sv -----
// ----------------------------------------------------------------------------
// lps_emit
// serializes a snapshot of the arrangement into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module lps_emit import lps_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire snap_t                                  snap,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]      snap_len,
    input  wire logic [MAX_ELEMENTS-1:0][ELEM_BITS-1:0] snap_elems,
    output logic                                        emit_idle,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [OUT_DATA_BITS-1:0]                    m_tdata,
    output logic                                        m_tlast,
    output logic                                        m_tuser
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic [MAX_ELEMENTS-1:0][ELEM_BITS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic                 final_reg, final_next;

    logic                 out_valid_reg, out_valid_next;
    logic [POS_BITS-1:0]  out_pos_reg, out_pos_next;
    logic [ELEM_BITS-1:0] out_elem_reg, out_elem_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_final_reg, out_final_next;

    logic adv;

    assign emit_idle = (cnt_reg == '0);
    // move one element into the output register when it is free or being taken
    assign adv = !emit_idle && (!out_valid_reg || m_tready);

    always_comb
    begin
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_pos_next   = out_pos_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;
        out_final_next = out_final_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = POS_BITS'(pos_reg);
            out_elem_next  = buf_reg[0];
            out_last_next  = (cnt_reg == CNT_W'(1));
            out_final_next = final_reg;
            buf_next       = buf_reg >> ELEM_BITS;
            cnt_next       = cnt_reg - CNT_W'(1);
            pos_next       = pos_reg + IDX_W'(1);
        end
        else if (snap.valid)
        begin
            buf_next   = snap_elems;
            cnt_next   = snap_len;
            pos_next   = '0;
            final_next = snap.final_arr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg       <= buf_next;
        pos_reg       <= pos_next;
        final_reg     <= final_next;
        out_pos_reg   <= out_pos_next;
        out_elem_reg  <= out_elem_next;
        out_last_reg  <= out_last_next;
        out_final_reg <= out_final_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'({out_elem_reg, out_pos_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_final_reg;

endmodule

`default_nettype wire

// ----- hdl/lexicographic_permutation_stepper_core.sv -----
// ----------------------------------------------------------------------------
// lexicographic_permutation_stepper_core
// steps a small loaded set of values through its lexicographic permutations
// ----------------------------------------------------------------------------
// usage:
//   apb register 0 (length, reset 4) sets how many elements are permuted,
//   clamped to 2..MAX_ELEMENTS; write it only while the block is idle.
//   input stream: tuser 0 is a load (tdata index and value), tuser 1 an
//   advance. a load writes one store entry and gives no output.
//   an advance emits the current arrangement as length output transactions
//   (position, element, tlast on the final one, tuser set when it is the
//   descending arrangement), then steps the store to the next permutation.
//   stepping: an advance takes a snapshot for emission, then runs the
//   odd-even transposition sort of the suffix and then the pivot swap;
//   emission runs from a snapshot buffer in parallel with the step. the
//   next advance waits until the step is done and that buffer is empty.
//   reset: length returns to 4 and the queues empty; store contents stay
//   undefined until loaded.
//   stall: the output register holds, the snapshot buffer waits, the next
//   advance waits in the 2-entry command queue and then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lexicographic_permutation_stepper_core_defines.svh"

module lexicographic_permutation_stepper_core import lps_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // [2:0] load_index, [18:3] load_value, [23:19] zero
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    // [0] mode
    input  wire logic                     s_tuser,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [2:0] position, [18:3] element, [23:19] zero
    output logic [OUT_DATA_BITS-1:0]      m_tdata,
    output logic                          m_tlast,
    // [0] final_arrangement
    output logic                          m_tuser
);

    localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
    localparam int LEN_EXT_W = LEN_BITS + 1;
    localparam logic [LEN_EXT_W-1:0] MAX_LEN = LEN_EXT_W'(MAX_ELEMENTS);
    localparam logic [LEN_EXT_W-1:0] MIN_LEN = LEN_EXT_W'(MIN_LENGTH);

    logic [LEN_BITS-1:0]     length_reg, length_next;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    cfg_wr;
    logic [LEN_EXT_W-1:0]    len_ext;
    logic [LEN_EXT_W-1:0]    len_clamped;
    logic [CNT_W-1:0]        active_len;

    logic  cmd_valid;
    cmd_t  cmd;
    logic  cmd_ready;
    logic  emit_idle;
    snap_t snap;
    logic [MAX_ELEMENTS-1:0][ELEM_BITS-1:0] snap_elems;

    // apb register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == REG_LENGTH) ? APB_DATA_BITS'(length_reg) : '0;

    always_comb
    begin
        length_next = length_reg;
        if (cfg_wr && (reg_idx == REG_LENGTH))
        begin
            length_next = pwdata[LEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_RESET;
        end
        else
        begin
            length_reg <= length_next;
        end
    end

    always_comb
    begin
        len_ext = LEN_EXT_W'(length_reg);
        if (len_ext < MIN_LEN)
        begin
            len_clamped = MIN_LEN;
        end
        else if (len_ext > MAX_LEN)
        begin
            len_clamped = MAX_LEN;
        end
        else
        begin
            len_clamped = len_ext;
        end
    end

    assign active_len = CNT_W'(len_clamped);

    lps_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    lps_engine #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_ready  (cmd_ready),
        .active_len (active_len),
        .emit_idle  (emit_idle),
        .snap       (snap),
        .snap_elems (snap_elems)
    );

    lps_emit #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_len   (active_len),
        .snap_elems (snap_elems),
        .emit_idle  (emit_idle),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // a snapshot never overwrites an arrangement still being emitted
    `LPS_ASSERT_IMP(a_snap_when_idle, clk, rst_n, snap.valid, emit_idle)
    // a taken snapshot always leaves elements to emit
    `LPS_ASSERT_NXT(a_snap_fills, clk, rst_n, snap.valid, !emit_idle)

endmodule

`default_nettype wire

// ----- sim/lps_permutation_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_permutation_checker
// tracks the element store and length register of the permutation stepper,
// predicts every emitted element and compares it with the output stream
// ----------------------------------------------------------------------------

module lps_permutation_checker import lps_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic                     pready,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    input  wire logic                     s_tuser,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [OUT_DATA_BITS-1:0] m_tdata,
    input  wire logic                     m_tlast,
    input  wire logic                     m_tuser,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [POS_BITS-1:0]  position;
        logic [ELEM_BITS-1:0] element;
        logic                 last;
        logic                 final_arr;
    } emitted_t;

    logic [ELEM_BITS-1:0] shadow_store [MAX_ELEMENTS_DEF];
    logic [LEN_BITS-1:0]  length_reg = LEN_RESET;
    emitted_t             awaited_elements [$];
    int                   errors = 0;

    // insertion sort of shadow_store[from .. upto-1]
    task automatic sort_tail(input int from, input int upto);
        logic [ELEM_BITS-1:0] v;
        int                   j;
        for (int i = from + 1; i < upto; i++)
        begin
            v = shadow_store[i];
            j = i;
            while (j > from && shadow_store[j-1] > v)
            begin
                shadow_store[j] = shadow_store[j-1];
                j--;
            end
            shadow_store[j] = v;
        end
    endtask

    // queue the current arrangement, then step to the next permutation
    task automatic emit_then_advance();
        int                   n;
        int                   pivot;
        int                   best;
        logic [ELEM_BITS-1:0] tmp;
        emitted_t             e;
        n = int'(length_reg);
        if (n < MIN_LENGTH)
            n = MIN_LENGTH;
        if (n > MAX_ELEMENTS_DEF)
            n = MAX_ELEMENTS_DEF;
        pivot = -1;
        for (int i = 0; i + 1 < n; i++)
            if (shadow_store[i] < shadow_store[i+1])
                pivot = i;
        for (int k = 0; k < n; k++)
        begin
            e.position  = POS_BITS'(k);
            e.element   = shadow_store[k];
            e.last      = (k == n - 1);
            e.final_arr = (pivot < 0);
            awaited_elements.push_back(e);
        end
        if (pivot < 0)
            sort_tail(0, n);
        else
        begin
            best = pivot + 1;
            for (int i = pivot + 1; i < n; i++)
                if (shadow_store[i] > shadow_store[pivot] && shadow_store[i] < shadow_store[best])
                    best = i;
            tmp                 = shadow_store[pivot];
            shadow_store[pivot] = shadow_store[best];
            shadow_store[best]  = tmp;
            sort_tail(pivot + 1, n);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        emitted_t got;
        emitted_t want;
        if (!rst_n)
        begin
            length_reg = LEN_RESET;
            awaited_elements.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_BITS-1:2] == REG_LENGTH)
                length_reg = pwdata[LEN_BITS-1:0];

            if (m_tvalid && m_tready)
            begin
                got.position  = m_tdata[POS_BITS-1:0];
                got.element   = m_tdata[POS_BITS +: ELEM_BITS];
                got.last      = m_tlast;
                got.final_arr = m_tuser;
                if (awaited_elements.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output transaction pos %0d element %h",
                             $time, got.position, got.element);
                end
                else
                begin
                    want = awaited_elements.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        if (got.position != want.position)
                            $display("%0t: position expected %0d actual %0d",
                                     $time, want.position, got.position);
                        if (got.element != want.element)
                            $display("%0t: element expected %h actual %h",
                                     $time, want.element, got.element);
                        if (got.last != want.last)
                            $display("%0t: tlast expected %b actual %b",
                                     $time, want.last, got.last);
                        if (got.final_arr != want.final_arr)
                            $display("%0t: final flag expected %b actual %b",
                                     $time, want.final_arr, got.final_arr);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == MODE_ADVANCE)
                    emit_then_advance();
                else
                    shadow_store[s_tdata[INDEX_BITS-1:0]] = s_tdata[INDEX_BITS +: ELEM_BITS];
            end
        end
        fail_count <= errors;
        pending    <= awaited_elements.size();
    end

endmodule

// ----- sim/tb_lexicographic_permutation_stepper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lexicographic_permutation_stepper_core
// loads value sets, sweeps the length register and advances through
// permutations with random gaps on both streams; the checker predicts
// and compares every output transaction
// ----------------------------------------------------------------------------

module tb_lexicographic_permutation_stepper_core;
    import lps_pkg::*;

    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 3 * MAX_ELEMENTS_DEF + 8;
    localparam int STALL_LIMIT   = 1000;

    localparam logic [APB_ADDR_BITS-1:0] LENGTH_ADDR   = {REG_LENGTH, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] UNMAPPED_ADDR = {~REG_LENGTH, 2'b00};

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr    = '0;
    logic [APB_DATA_BITS-1:0] pwdata   = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic                     s_tuser  = MODE_LOAD;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tlast;
    logic                     m_tuser;
    int                       fail_count;
    int                       pending;
    bit                       burst_mode = 1'b0;
    int                       rx_gap     = 0;

    always #2 clk = ~clk;

    lexicographic_permutation_stepper_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    lps_permutation_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 11);
    endfunction

    // receiver: a fresh stall length after every accepted transaction
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            rx_gap = draw_gap();
        else if (rx_gap > 0)
            rx_gap--;
        m_tready <= (rx_gap == 0);
    end

    // returns at the edge that accepted the item, tvalid still high
    task automatic send_item(input logic mode, input logic [INDEX_BITS-1:0] index,
                             input logic [ELEM_BITS-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= IN_DATA_BITS'({value, index});
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_advance();
        send_item(MODE_ADVANCE, INDEX_BITS'($urandom), ELEM_BITS'($urandom));
    endtask

    // hold the input until all emitted elements are back and the engine settles
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits are junk, only the low nibble is the length
    task automatic set_length(input logic [LEN_BITS-1:0] len);
        drain();
        write_reg(LENGTH_ADDR, {(APB_DATA_BITS-LEN_BITS)'($urandom), len});
    endtask

    // loads positions 0..count-1; returns the number of transactions sent
    task automatic load_arrangement(input int count, output int sent);
        logic [ELEM_BITS-1:0] vals [MAX_ELEMENTS_DEF];
        logic [ELEM_BITS-1:0] tmp;
        int                   style;
        int                   span;
        style = $urandom_range(0, 4);
        // narrow span gives repeated values
        span  = (style == 4) ? 3 : 65535;
        for (int i = 0; i < count; i++)
            vals[i] = ELEM_BITS'($urandom_range(0, span));
        if (style != 3)
            for (int i = 0; i < count; i++)
                for (int j = 0; j + 1 < count - i; j++)
                    if (vals[j] > vals[j+1])
                    begin
                        tmp       = vals[j];
                        vals[j]   = vals[j+1];
                        vals[j+1] = tmp;
                    end
        // style 2 loads descending so the final arrangement comes first
        for (int i = 0; i < count; i++)
            send_item(MODE_LOAD, INDEX_BITS'(i), (style == 2) ? vals[count-1-i] : vals[i]);
        sent = count;
    endtask

    initial
    begin : stimulus
        logic [LEN_BITS-1:0]  len_pick [7];
        logic [LEN_BITS-1:0]  len;
        logic [ELEM_BITS-1:0] seed_vals [MAX_ELEMENTS_DEF];
        int                   sent;
        int                   loaded;
        int                   phase;
        int                   n;
        int                   advances;

        len_pick  = '{4'd2, 4'd3, 4'd8, 4'd15, 4'd1, 4'd9, 4'd5};
        seed_vals = '{16'h0000, 16'h0012, 16'h5555, 16'hAAAA,
                      16'hC000, 16'hF0F0, 16'hFFFE, 16'hFFFF};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry written before any advance reads it
        for (int i = 0; i < MAX_ELEMENTS_DEF; i++)
            send_item(MODE_LOAD, INDEX_BITS'(i), seed_vals[i]);
        repeat (3) send_advance();
        drain();
        // unmapped register, length must stay at its reset value
        write_reg(UNMAPPED_ADDR, 32'h0000_0002);
        send_advance();
        set_length(4'd2);
        repeat (3) send_advance();
        // equal neighbors: no pivot, flagged final
        send_item(MODE_LOAD, 3'd0, 16'h0000);
        send_item(MODE_LOAD, 3'd1, 16'h0000);
        send_advance();
        set_length(4'd8);
        repeat (2) send_advance();
        set_length(4'd15);
        send_advance();
        set_length(4'd0);
        send_advance();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            len = (phase < 7) ? len_pick[phase] : LEN_BITS'($urandom_range(0, 15));
            set_length(len);
            n = int'(len);
            if (n < MIN_LENGTH)
                n = MIN_LENGTH;
            if (n > MAX_ELEMENTS_DEF)
                n = MAX_ELEMENTS_DEF;
            load_arrangement(n, loaded);
            sent += loaded;
            advances = $urandom_range(3, 8);
            for (int a = 0; a < advances; a++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(MODE_LOAD, INDEX_BITS'($urandom), ELEM_BITS'($urandom));
                    sent++;
                end
                // one full pause mid-stream with the pipeline emptied
                if (phase == 1 && a == advances / 2)
                    drain();
                send_advance();
                sent++;
            end
            phase++;
        end

        drain();
        if (fail_count == 0)
            $display("tb_lexicographic_permutation_stepper_core: PASS");
        else
            $display("tb_lexicographic_permutation_stepper_core: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_lexicographic_permutation_stepper_core: FAIL");
        $finish;
    end

endmodule
